// ===== design/integer_to_decimal_ascii_assert.svh =====
// Assertion macros shared by the checker of integer_to_decimal_ascii.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef INTEGER_TO_DECIMAL_ASCII_ASSERT_SVH
`define INTEGER_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define I2DA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define I2DA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/i2da_pkg.sv =====
// Package for integer_to_decimal_ascii: sizes, character codes, opcodes,
// and the control struct that drives the BCD digit cells. No dependencies.
`timescale 1ns / 1ps

package i2da_pkg;

	localparam int VALUE_WIDTH  = 64;
	localparam int SIGNED_WIDTH = 32;
	localparam int DIGIT_DEPTH  = 20;
	localparam int CNT_W        = $clog2(VALUE_WIDTH);
	localparam int REM_W        = $clog2(DIGIT_DEPTH + 1);

	localparam logic [7:0] ASCII_ZERO  = 8'd48;
	localparam logic [7:0] ASCII_MINUS = 8'd45;

	localparam logic OP_SIGNED   = 1'b0;
	localparam logic OP_UNSIGNED = 1'b1;

	typedef logic [3:0] digit_t;

	// Commands broadcast to every digit cell
	typedef struct packed {
		logic clr;  // clear digit to zero
		logic dbl;  // double-dabble step: adjust, shift in a bit
		logic shl;  // take the lower neighbor's digit
	} i2da_ctl_t;

endpackage

// ===== design/integer_to_decimal_ascii.sv =====
// Operation: each input bit is shifted through the chain of 20 BCD digit cells (the low
// SIGNED_WIDTH bits of a signed item, all VALUE_WIDTH bits of an unsigned one), then leading
// zeros are dropped, then one character per cycle goes into the output register unless stalled.
// Items are taken one at a time: a new item is accepted only after the last character of
// the previous one has been loaded into the output register.
// Reset: arst_n clears the sequencer and the output valid asynchronously;
// digit cells and data registers are reloaded at each transaction.
`timescale 1ns / 1ps

module integer_to_decimal_ascii (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] value
	input  logic [0:0]  s_tuser,   // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] char_out
	output logic        m_tlast    // last
);
	import i2da_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_SKIP = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]             state_q;
	logic [VALUE_WIDTH-1:0] mag_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [REM_W-1:0]       rem_q;
	logic                   neg_q;
	logic                   ov_q;
	logic [7:0]             char_q;
	logic                   last_q;

	i2da_ctl_t ctl;
	digit_t    dig   [DIGIT_DEPTH];
	logic      carry [DIGIT_DEPTH];
	digit_t    top_dig;

	logic                    accept;
	logic                    slot_free;
	logic                    ov_set;
	logic [SIGNED_WIDTH-1:0] low_val;
	logic [SIGNED_WIDTH-1:0] abs_val;

	assign accept    = s_tvalid && s_tready;
	assign slot_free = !ov_q || m_tready;
	assign ov_set    = (state_q == ST_EMIT) && slot_free;
	assign s_tready  = (state_q == ST_IDLE);
	assign top_dig   = dig[DIGIT_DEPTH-1];

	assign low_val = s_tdata[SIGNED_WIDTH-1:0];
	assign abs_val = low_val[SIGNED_WIDTH-1] ? (~low_val + 1'b1) : low_val;

	// Cell commands
	always_comb begin
		ctl.clr = accept;
		ctl.dbl = (state_q == ST_CONV);
		ctl.shl = ((state_q == ST_SKIP) && (top_dig == 4'd0) && (rem_q > REM_W'(1))) ||
			((state_q == ST_EMIT) && slot_free && !neg_q);
	end

	// Digit cell chain, least significant digit at index 0
	for (genvar i = 0; i < DIGIT_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			i2da_cell u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.bit_in    (mag_q[VALUE_WIDTH-1]),
				.dig_in    (4'd0),
				.carry_out (carry[i]),
				.dig       (dig[i])
			);
		end else begin : g_next
			i2da_cell u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.bit_in    (carry[i-1]),
				.dig_in    (dig[i-1]),
				.carry_out (carry[i]),
				.dig       (dig[i])
			);
		end
	end

	// Magnitude shift register and bit counter
	always_ff @(posedge clk) begin
		if (accept) begin
			if (s_tuser[0] == OP_SIGNED) begin
				mag_q <= VALUE_WIDTH'(abs_val) << (VALUE_WIDTH - SIGNED_WIDTH);
				cnt_q <= CNT_W'(VALUE_WIDTH - SIGNED_WIDTH);
			end else begin
				mag_q <= s_tdata[VALUE_WIDTH-1:0];
				cnt_q <= '0;
			end
		end else if (state_q == ST_CONV) begin
			mag_q <= mag_q << 1;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q    <= 1'b0;
			neg_q   <= 1'b0;
			rem_q   <= '0;
		end else begin
			if (ov_set) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						neg_q   <= (s_tuser[0] == OP_SIGNED) && low_val[SIGNED_WIDTH-1];
						rem_q   <= REM_W'(DIGIT_DEPTH);
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (cnt_q == CNT_W'(VALUE_WIDTH - 1)) begin
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if ((top_dig == 4'd0) && (rem_q > REM_W'(1))) begin
						rem_q <= rem_q - 1'b1;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						if (neg_q) begin
							neg_q <= 1'b0;
						end else begin
							rem_q <= rem_q - 1'b1;
							if (rem_q == REM_W'(1)) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Character payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && slot_free) begin
			if (neg_q) begin
				char_q <= ASCII_MINUS;
				last_q <= 1'b0;
			end else begin
				char_q <= ASCII_ZERO + {4'd0, top_dig};
				last_q <= (rem_q == REM_W'(1));
			end
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = char_q;
	assign m_tlast  = last_q;

endmodule

// ===== design/i2da_cell.sv =====
// One BCD digit cell of the conversion chain: add-3 adjust and shift during
// conversion, digit hand-off toward the top during output. Uses i2da_pkg.
`timescale 1ns / 1ps

module i2da_cell (
	input  logic                  clk,
	input  i2da_pkg::i2da_ctl_t   ctl,
	input  logic                  bit_in,
	input  i2da_pkg::digit_t      dig_in,
	output logic                  carry_out,
	output i2da_pkg::digit_t      dig
);
	import i2da_pkg::*;

	digit_t dig_q;
	digit_t adj;

	// Add 3 when the digit is 5 or more so the shift carries correctly
	always_comb begin
		adj = (dig_q >= 4'd5) ? (dig_q + 4'd3) : dig_q;
	end

	assign carry_out = adj[3];
	assign dig       = dig_q;

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			dig_q <= '0;
		end else if (ctl.dbl) begin
			dig_q <= {adj[2:0], bit_in};
		end else if (ctl.shl) begin
			dig_q <= dig_in;
		end
	end

endmodule

// ===== design/i2da_checker.sv =====
// Port-level checker for integer_to_decimal_ascii, bound to the top level.
// Uses i2da_pkg and the macros in integer_to_decimal_ascii_assert.svh.
`timescale 1ns / 1ps

`include "integer_to_decimal_ascii_assert.svh"

module i2da_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);
	import i2da_pkg::*;

	logic is_digit;

	assign is_digit = (m_tdata >= ASCII_ZERO) && (m_tdata <= ASCII_ZERO + 8'd9);

	// A stalled output transaction stays offered
	`I2DA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "output dropped while stalled")

	// Only a minus sign or a decimal digit leaves the block
	`I2DA_ASSERT_NOW(a_char_set, m_tvalid, (m_tdata == ASCII_MINUS) || is_digit, "bad character")

	// A minus sign is never the final character
	`I2DA_ASSERT_NOW(a_minus_not_last, m_tvalid && (m_tdata == ASCII_MINUS), !m_tlast, "minus last")

	// Input closes after a transaction is accepted, since conversion keeps the block busy
	`I2DA_ASSERT_NEXT(a_busy_after_in, s_tvalid && s_tready, !s_tready, "input open in conversion")

endmodule

bind integer_to_decimal_ascii i2da_checker u_i2da_checker (.*);
